// File: rtl/line_activity_pulse_detector_core_defines.svh
// Assertion macros shared by the line activity pulse detector RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef LINE_ACTIVITY_PULSE_DETECTOR_CORE_DEFINES_SVH
`define LINE_ACTIVITY_PULSE_DETECTOR_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define LAPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define LAPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/lapd_pkg.sv
// Package of the line activity pulse detector: widths, register codes,
// the controller-datapath command and status structs and a helper function.
`default_nettype none

package lapd_pkg;

  localparam int CNT_W     = 24;
  localparam int TIME_W    = 32;
  localparam int PCT_W     = 7;
  localparam int CFG_W     = 24;
  localparam int NUM_REGS  = 4;
  localparam int ADDR_W    = $clog2(NUM_REGS) + 2;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = CNT_W + PCT_W;
  localparam int DIV_STEPS = PCT_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [PCT_W-1:0] PCT_SCALE = PCT_W'(100);

  localparam logic [CFG_W-1:0] RST_WINDOW_LEN = CFG_W'(30000);
  localparam logic [CFG_W-1:0] RST_EDGE_THR   = CFG_W'(50);
  localparam logic [CFG_W-1:0] RST_PULSE_MIN  = CFG_W'(6);
  localparam logic [CFG_W-1:0] RST_PULSE_MAX  = CFG_W'(20);

  typedef enum logic [1:0] {
    REG_WINDOW_LEN = 2'd0,
    REG_EDGE_THR   = 2'd1,
    REG_PULSE_MIN  = 2'd2,
    REG_PULSE_MAX  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] window_len;
    logic [CFG_W-1:0] edge_thr;
    logic [CFG_W-1:0] pulse_min;
    logic [CFG_W-1:0] pulse_max;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic load_mul;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic close_hit;
    logic div_last;
  } dp_sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

// File: rtl/lapd_in_if.sv
// Sample channel of the line activity pulse detector: valid, ready, payload.
// Depends on lapd_pkg for the field widths.
`default_nettype none

interface lapd_in_if import lapd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              window_start;
  logic              line_level;
  logic [TIME_W-1:0] time_now_us;

  modport source (output valid, output window_start, output line_level,
                  output time_now_us, input ready);
  modport sink (input valid, input window_start, input line_level,
                input time_now_us, output ready);
endinterface

`default_nettype wire

// File: rtl/lapd_out_if.sv
// Result channel of the line activity pulse detector: valid, ready, payload.
// Depends on lapd_pkg for the field widths.
`default_nettype none

interface lapd_out_if import lapd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] edge_total;
  logic [CNT_W-1:0] shortest_pulse_us;
  logic [PCT_W-1:0] high_percent;
  logic             line_active;
  logic             serial_like;

  modport source (output valid, output edge_total, output shortest_pulse_us,
                  output high_percent, output line_active, output serial_like,
                  input ready);
  modport sink (input valid, input edge_total, input shortest_pulse_us,
                input high_percent, input line_active, input serial_like,
                output ready);
endinterface

`default_nettype wire

// File: rtl/lapd_regs.sv
// APB-style configuration registers of the line activity pulse detector.
// Depends on lapd_pkg for the register codes and the cfg_t struct.
`default_nettype none

module lapd_regs import lapd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_len <= RST_WINDOW_LEN;
      cfg.edge_thr   <= RST_EDGE_THR;
      cfg.pulse_min  <= RST_PULSE_MIN;
      cfg.pulse_max  <= RST_PULSE_MAX;
    end else if (wr_en) begin
      unique case (idx)
        REG_WINDOW_LEN: cfg.window_len <= pwdata[CFG_W-1:0];
        REG_EDGE_THR:   cfg.edge_thr   <= pwdata[CFG_W-1:0];
        REG_PULSE_MIN:  cfg.pulse_min  <= pwdata[CFG_W-1:0];
        REG_PULSE_MAX:  cfg.pulse_max  <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WINDOW_LEN: prdata = DATA_W'(cfg.window_len);
      REG_EDGE_THR:   prdata = DATA_W'(cfg.edge_thr);
      REG_PULSE_MIN:  prdata = DATA_W'(cfg.pulse_min);
      REG_PULSE_MAX:  prdata = DATA_W'(cfg.pulse_max);
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/lapd_dp.sv
// Datapath of the line activity pulse detector: window state, counters,
// percentage multiply and shift-subtract divider, result register.
// Depends on lapd_pkg; driven by lapd_ctrl through dp_cmd_t.
`default_nettype none

module lapd_dp import lapd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dp_cmd_t           cmd,
  output dp_sts_t                sts,
  input  wire cfg_t              cfg,
  input  wire logic              window_start,
  input  wire logic              line_level,
  input  wire logic [TIME_W-1:0] time_now_us,
  output logic      [CNT_W-1:0]  edge_total,
  output logic      [CNT_W-1:0]  shortest_pulse_us,
  output logic      [PCT_W-1:0]  high_percent,
  output logic                   line_active,
  output logic                   serial_like
);

  logic              window_open;
  logic              previous_level;
  logic [TIME_W-1:0] previous_edge_time;
  logic [TIME_W-1:0] window_end_time;
  logic [CNT_W-1:0]  edge_counter;
  logic [CNT_W-1:0]  shortest_seen;
  logic [CNT_W-1:0]  high_sample_counter;
  logic [CNT_W-1:0]  sample_counter;

  logic [PROD_W-1:0] rem;
  logic [PCT_W-1:0]  quot;
  logic [STEP_W-1:0] step;

  logic [TIME_W-1:0] end_diff;
  logic [TIME_W-1:0] span_full;
  logic [CNT_W-1:0]  span;
  logic              close_cond;
  logic [PROD_W-1:0] den_shift;
  logic              rem_ge;
  logic              active;

  assign end_diff   = time_now_us - window_end_time;
  assign close_cond = ~end_diff[TIME_W-1];
  assign span_full  = time_now_us - previous_edge_time;
  assign span       = (|span_full[TIME_W-1:CNT_W]) ? CNT_MAX : span_full[CNT_W-1:0];

  assign den_shift = PROD_W'(sample_counter) << step;
  assign rem_ge    = rem >= den_shift;
  assign active    = edge_counter >= cfg.edge_thr;

  assign sts.close_hit = window_open && !window_start && close_cond;
  assign sts.div_last  = (step == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_open         <= 1'b0;
      previous_level      <= 1'b0;
      previous_edge_time  <= '0;
      window_end_time     <= '0;
      edge_counter        <= '0;
      shortest_seen       <= CNT_MAX;
      high_sample_counter <= '0;
      sample_counter      <= '0;
    end else if (cmd.accept) begin
      if (window_start) begin
        window_open         <= 1'b1;
        previous_level      <= line_level;
        previous_edge_time  <= time_now_us;
        window_end_time     <= time_now_us + TIME_W'(cfg.window_len);
        edge_counter        <= '0;
        shortest_seen       <= CNT_MAX;
        high_sample_counter <= '0;
        sample_counter      <= '0;
      end else if (window_open) begin
        if (close_cond) begin
          window_open <= 1'b0;
        end else begin
          sample_counter <= sat_inc(sample_counter);
          if (line_level) begin
            high_sample_counter <= sat_inc(high_sample_counter);
          end
          if (line_level != previous_level) begin
            if (span < shortest_seen) begin
              shortest_seen <= span;
            end
            previous_edge_time <= time_now_us;
            previous_level     <= line_level;
            edge_counter       <= sat_inc(edge_counter);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mul) begin
      rem  <= PROD_W'(high_sample_counter) * PROD_W'(PCT_SCALE);
      quot <= '0;
      step <= STEP_W'(DIV_STEPS - 1);
    end else if (cmd.div_step) begin
      if (rem_ge) begin
        rem <= rem - den_shift;
      end
      quot <= {quot[PCT_W-2:0], rem_ge};
      step <= step - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      edge_total        <= edge_counter;
      shortest_pulse_us <= shortest_seen;
      high_percent      <= (sample_counter == '0) ? '0 : quot;
      line_active       <= active;
      serial_like       <= active && (shortest_seen >= cfg.pulse_min) &&
                           (shortest_seen <= cfg.pulse_max);
    end
  end

endmodule

`default_nettype wire

// File: rtl/lapd_ctrl.sv
// Controller of the line activity pulse detector: sequences sample intake,
// the percentage multiply and divide, and the result register handshake.
// Depends on lapd_pkg and on the assertion macros header.
`default_nettype none
`include "line_activity_pulse_detector_core_defines.svh"

module lapd_ctrl import lapd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_COLLECT = 4'b0001,
    ST_MUL     = 4'b0010,
    ST_DIV     = 4'b0100,
    ST_LOAD    = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_full;
  logic   out_full_next;

  assign in_ready  = (state == ST_COLLECT);
  assign out_valid = out_full;

  always_comb begin
    state_next   = state;
    cmd.accept   = 1'b0;
    cmd.load_mul = 1'b0;
    cmd.div_step = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      ST_COLLECT: begin
        cmd.accept = in_valid;
        if (in_valid && sts.close_hit) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.load_mul = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!out_full || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    out_full_next = out_full;
    if (cmd.load_out) begin
      out_full_next = 1'b1;
    end else if (out_ready) begin
      out_full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_COLLECT;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  `LAPD_ASSERT(a_no_overwrite, !(cmd.load_out && out_full && !out_ready), "result overwritten")
  `LAPD_ASSERT_NEXT(a_close_to_mul, in_valid && in_ready && sts.close_hit, state == ST_MUL, "close not followed by multiply")
  `LAPD_ASSERT_NEXT(a_div_runs, state == ST_DIV && !sts.div_last, state == ST_DIV, "divider left early")
  `LAPD_ASSERT(a_ready_only_collect, !(in_ready && (cmd.div_step || cmd.load_mul || cmd.load_out)), "sample taken while busy")

endmodule

`default_nettype wire

// File: rtl/line_activity_pulse_detector_core.sv
// Line activity pulse detector: one sample per cycle, window open or closed, unless intake is stalled.
// A closing sample stalls intake for 1 multiply, 7 divide steps and 1 load; the
// load waits longer while the previous result is still held in the output register.
// Its result is valid once the load step registers it (later if an earlier
// result is still held) and waits in the output register while new samples are taken.
// Synchronous active-high rst restores register defaults and closes the window.
`default_nettype none

module line_activity_pulse_detector_core import lapd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  lapd_in_if.sink                samples,
  lapd_out_if.source             results,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;
  logic    out_valid;

  assign samples.ready = in_ready;
  assign results.valid = out_valid;

  lapd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lapd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (results.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lapd_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .cfg               (cfg),
    .window_start      (samples.window_start),
    .line_level        (samples.line_level),
    .time_now_us       (samples.time_now_us),
    .edge_total        (results.edge_total),
    .shortest_pulse_us (results.shortest_pulse_us),
    .high_percent      (results.high_percent),
    .line_active       (results.line_active),
    .serial_like       (results.serial_like)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_line_activity_pulse_detector_core.sv
// Self-checking testbench of line_activity_pulse_detector_core: drives timestamped line
// samples and APB register writes, predicts each window report and checks every result.
// Depends on lapd_pkg, lapd_in_if, lapd_out_if and the core RTL.
`default_nettype none

module tb_line_activity_pulse_detector_core import lapd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned ITEM_GOAL      = 1900;

  typedef struct packed {
    logic [CNT_W-1:0] edge_total;
    logic [CNT_W-1:0] shortest_pulse_us;
    logic [PCT_W-1:0] high_percent;
    logic             line_active;
    logic             serial_like;
  } window_report_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lapd_in_if  samples_if ();
  lapd_out_if results_if ();

  line_activity_pulse_detector_core uut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if.sink),
    .results (results_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [CFG_W-1:0]  cfg_window_len;
  logic [CFG_W-1:0]  cfg_edge_thr;
  logic [CFG_W-1:0]  cfg_pulse_min;
  logic [CFG_W-1:0]  cfg_pulse_max;

  bit                win_open;
  logic              last_level;
  logic [TIME_W-1:0] last_edge_t;
  logic [TIME_W-1:0] end_t;
  logic [CNT_W-1:0]  edge_cnt;
  logic [CNT_W-1:0]  shortest;
  logic [CNT_W-1:0]  high_cnt;
  logic [CNT_W-1:0]  sample_cnt;

  window_report_t    due_reports [$];
  window_report_t    want;

  int unsigned       effective_items;
  int unsigned       reports_seen;
  int unsigned       config_writes;
  int unsigned       mismatches;
  int unsigned       idle_cycles;
  int unsigned       sample_gap_max = 10;
  bit                result_stall_en = 1'b1;
  int unsigned       hold_req;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic reset_line_model();
    cfg_window_len = RST_WINDOW_LEN;
    cfg_edge_thr   = RST_EDGE_THR;
    cfg_pulse_min  = RST_PULSE_MIN;
    cfg_pulse_max  = RST_PULSE_MAX;
    win_open       = 1'b0;
    last_level     = 1'b0;
    last_edge_t    = '0;
    end_t          = '0;
    edge_cnt       = '0;
    shortest       = CNT_MAX;
    high_cnt       = '0;
    sample_cnt     = '0;
  endtask

  task automatic predict_line_sample(input logic st, input logic lv,
                                     input logic [TIME_W-1:0] t, output bit counted);
    logic [TIME_W-1:0] late;
    logic [TIME_W-1:0] span;
    longint unsigned   pct;
    window_report_t    rpt;
    counted = st || win_open;
    if (st) begin
      win_open    = 1'b1;
      last_level  = lv;
      last_edge_t = t;
      end_t       = t + TIME_W'(cfg_window_len);
      edge_cnt    = '0;
      shortest    = CNT_MAX;
      high_cnt    = '0;
      sample_cnt  = '0;
    end else if (win_open) begin
      late = t - end_t;
      if (!late[TIME_W-1]) begin
        pct = 0;
        if (sample_cnt != 0)
          pct = (64'(high_cnt) * 64'd100) / 64'(sample_cnt);
        if (pct > 100)
          pct = 100;
        rpt.edge_total        = edge_cnt;
        rpt.shortest_pulse_us = shortest;
        rpt.high_percent      = PCT_W'(pct);
        rpt.line_active       = (edge_cnt >= cfg_edge_thr);
        rpt.serial_like       = rpt.line_active && (shortest >= cfg_pulse_min) &&
                                (shortest <= cfg_pulse_max);
        due_reports.push_back(rpt);
        win_open = 1'b0;
      end else begin
        sample_cnt = (sample_cnt == CNT_MAX) ? sample_cnt : sample_cnt + 1'b1;
        if (lv)
          high_cnt = (high_cnt == CNT_MAX) ? high_cnt : high_cnt + 1'b1;
        if (lv != last_level) begin
          span = t - last_edge_t;
          if (span > TIME_W'(CNT_MAX))
            span = TIME_W'(CNT_MAX);
          if (span[CNT_W-1:0] < shortest)
            shortest = span[CNT_W-1:0];
          last_edge_t = t;
          last_level  = lv;
          edge_cnt    = (edge_cnt == CNT_MAX) ? edge_cnt : edge_cnt + 1'b1;
        end
      end
    end
  endtask

  task automatic send_line_sample(input logic st, input logic lv, input logic [TIME_W-1:0] t);
    int unsigned gap;
    bit          counted;
    gap = (sample_gap_max == 0) ? 0 : $urandom_range(0, sample_gap_max);
    if (gap != 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid        <= 1'b1;
    samples_if.window_start <= st;
    samples_if.line_level   <= lv;
    samples_if.time_now_us  <= t;
    do @(posedge clk); while (!samples_if.ready);
    predict_line_sample(st, lv, t, counted);
    if (counted)
      effective_items++;
  endtask

  task automatic wait_block_idle();
    samples_if.valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic configure_detector(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] thr,
                                    input logic [CFG_W-1:0] pmin, input logic [CFG_W-1:0] pmax);
    logic [CFG_W-1:0] values [NUM_REGS];
    reg_idx_t         idx;
    values = '{len, thr, pmin, pmax};
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = reg_idx_t'(i);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= {8'($urandom), values[i]};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_window_len = values[REG_WINDOW_LEN];
    cfg_edge_thr   = values[REG_EDGE_THR];
    cfg_pulse_min  = values[REG_PULSE_MIN];
    cfg_pulse_max  = values[REG_PULSE_MAX];
    config_writes += NUM_REGS;
  endtask

  task automatic send_window_burst(input int unsigned max_samples, input bit allow_noise);
    logic [TIME_W-1:0] len;
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] off;
    logic [TIME_W-1:0] stride;
    logic [TIME_W-1:0] late;
    int unsigned       n;
    int unsigned       toggle_pct;
    logic              lv;
    len        = TIME_W'(cfg_window_len);
    t0         = $urandom();
    n          = (len == 0) ? 0 : $urandom_range(0, max_samples);
    toggle_pct = $urandom_range(0, 100);
    stride     = (len / (n + 1)) * 2 + 1;
    lv         = 1'($urandom);
    off        = '0;
    if (allow_noise && $urandom_range(0, 9) == 0)
      send_line_sample(1'b0, 1'($urandom), $urandom());
    send_line_sample(1'b1, lv, t0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < toggle_pct)
        lv = ~lv;
      off = off + $urandom_range(0, stride);
      if (off >= len)
        off = len - 1;
      if (allow_noise && $urandom_range(0, 99) < 4)
        send_line_sample($urandom_range(0, 19) == 0, 1'($urandom), $urandom());
      else
        send_line_sample(1'b0, lv, t0 + off);
    end
    if ($urandom_range(0, 9) != 0) begin
      late = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 32'h7F00_0000);
      send_line_sample(1'b0, 1'($urandom), t0 + len + late);
    end
  endtask

  task automatic test_closed_line_ignored();
    send_line_sample(1'b0, 1'b1, 32'hFFFF_FFFF);
    send_line_sample(1'b0, 1'b0, 32'h0000_0000);
    send_line_sample(1'b1, 1'b0, 32'h0001_0000);
    send_line_sample(1'b0, 1'b1, 32'h0001_000A);
    send_line_sample(1'b0, 1'b0, 32'h0001_0023);
    send_line_sample(1'b0, 1'b1, 32'h0001_0000 + 30000);
  endtask

  task automatic test_wrap_and_long_pulse();
    wait_block_idle();
    configure_detector(24'd100, 24'd0, 24'd0, CNT_MAX);
    send_line_sample(1'b1, 1'b1, 32'hFFFF_FFF0);
    send_line_sample(1'b0, 1'b0, 32'hFFFF_FFF8);
    send_line_sample(1'b0, 1'b1, 32'h0000_0005);
    send_line_sample(1'b0, 1'b0, 32'hFFFF_FF00);
    send_line_sample(1'b0, 1'b0, 32'h0000_0054);
  endtask

  task automatic test_restart_while_open();
    send_line_sample(1'b1, 1'b0, 32'd1000);
    send_line_sample(1'b0, 1'b1, 32'd1010);
    send_line_sample(1'b1, 1'b1, 32'd2000);
    send_line_sample(1'b0, 1'b1, 32'd2050);
    send_line_sample(1'b0, 1'b0, 32'd2100);
  endtask

  task automatic test_zero_length_window();
    wait_block_idle();
    configure_detector(24'd0, 24'd0, 24'd0, CNT_MAX);
    send_line_sample(1'b1, 1'b0, 32'd500);
    send_line_sample(1'b0, 1'b1, 32'd499);
    send_line_sample(1'b0, 1'b0, 32'd500);
    send_line_sample(1'b1, 1'b0, 32'd700);
    send_line_sample(1'b0, 1'b1, 32'd700);
  endtask

  task automatic test_longest_window();
    wait_block_idle();
    configure_detector(CNT_MAX, CNT_MAX, CNT_MAX, 24'd0);
    send_line_sample(1'b1, 1'b1, 32'd0);
    send_line_sample(1'b0, 1'b0, 32'h00FF_FFFE);
    send_line_sample(1'b0, 1'b1, 32'h00FF_FFFF);
  endtask

  task automatic test_output_backpressure();
    wait_block_idle();
    configure_detector(24'd4, 24'd1, 24'd0, 24'd3);
    sample_gap_max = 0;
    hold_req       = 400;
    repeat (15) send_window_burst(3, 1'b0);
    sample_gap_max = 10;
  endtask

  task automatic test_random_windows();
    logic [CFG_W-1:0] len;
    logic [CFG_W-1:0] thr;
    logic [CFG_W-1:0] pmin;
    logic [CFG_W-1:0] pmax;
    while (effective_items < ITEM_GOAL) begin
      wait_block_idle();
      case ($urandom_range(0, 9))
        0:       len = 24'd1;
        1:       len = CNT_MAX;
        2, 3, 4: len = CFG_W'($urandom_range(2, 64));
        default: len = CFG_W'($urandom_range(65, 3000));
      endcase
      case ($urandom_range(0, 7))
        0:       thr = 24'd0;
        1:       thr = CNT_MAX;
        default: thr = CFG_W'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 7))
        0:       pmin = 24'd0;
        1:       pmin = CNT_MAX;
        default: pmin = CFG_W'($urandom_range(0, 30));
      endcase
      case ($urandom_range(0, 7))
        0:       pmax = CNT_MAX;
        1:       pmax = 24'd0;
        default: pmax = CFG_W'($urandom_range(0, 150));
      endcase
      configure_detector(len, thr, pmin, pmax);
      sample_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 10;
      result_stall_en = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(3, 8)) send_window_burst(40, 1'b1);
    end
  endtask

  task automatic check_field(input string field, input logic [31:0] expv, input logic [31:0] got);
    if (expv !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch in %s of report %0d: expected %0d, got %0d",
                 field, reports_seen, expv, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Report %0d arrived with no window closed", reports_seen);
      end else begin
        want = due_reports.pop_front();
        check_field("edge_total", 32'(want.edge_total), 32'(results_if.edge_total));
        check_field("shortest_pulse_us", 32'(want.shortest_pulse_us),
                    32'(results_if.shortest_pulse_us));
        check_field("high_percent", 32'(want.high_percent), 32'(results_if.high_percent));
        check_field("line_active", 32'(want.line_active), 32'(results_if.line_active));
        check_field("serial_like", 32'(want.serial_like), 32'(results_if.serial_like));
      end
      reports_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned n;
    results_if.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req != 0) begin
        n        = hold_req;
        hold_req = 0;
      end else begin
        n = result_stall_en ? $urandom_range(0, 10) : 0;
      end
      if (n != 0) begin
        results_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      results_if.ready <= 1'b1;
      @(posedge clk);
      while (!results_if.valid && hold_req == 0) @(posedge clk);
    end
  end

  initial begin
    samples_if.valid        = 1'b0;
    samples_if.window_start = 1'b0;
    samples_if.line_level   = 1'b0;
    samples_if.time_now_us  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    reset_line_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_closed_line_ignored();
    test_wrap_and_long_pulse();
    test_restart_while_open();
    test_zero_length_window();
    test_longest_window();
    test_output_backpressure();
    test_random_windows();

    wait_block_idle();
    repeat (20) @(posedge clk);
    $display("Sent %0d line samples, checked %0d window reports, %0d register writes",
             effective_items, reports_seen, config_writes);
    if (mismatches == 0 && due_reports.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// File: line_activity_pulse_detector_core.f
+incdir+rtl
rtl/lapd_pkg.sv
rtl/lapd_in_if.sv
rtl/lapd_out_if.sv
rtl/lapd_regs.sv
rtl/lapd_dp.sv
rtl/lapd_ctrl.sv
rtl/line_activity_pulse_detector_core.sv
tb/sv/tb_line_activity_pulse_detector_core.sv
